FILE: rtl/core/grmb_pkg.sv
// grmb_pkg: shared types, codes and fixed-point helpers of the gradient ramp map
// used by every file of the block; depends on nothing
`default_nettype none

package grmb_pkg;

    localparam int MAX_STOPS_DEF = 16;
    localparam int SV_W          = 24;
    localparam int DIV_STEPS     = 16;
    localparam int PADDR_W       = 4;

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_MODE    = 2'd1;
    localparam logic [1:0] REG_OPACITY = 2'd2;

    // blend modes
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY = 3'd1;
    localparam logic [2:0] MODE_SCREEN   = 3'd2;
    localparam logic [2:0] MODE_OVERLAY  = 3'd3;
    localparam logic [2:0] MODE_ADD      = 3'd4;
    localparam logic [2:0] MODE_SUB      = 3'd5;

    typedef logic signed [SV_W-1:0] t_sv;

    localparam t_sv ONE_SV = t_sv'(65535);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_ADJ,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_INTERP,
        PH_OPAC,
        PH_BLEND
    } t_phase;

    // search token walking the row of stop cells
    typedef struct packed {
        logic        valid;
        logic [15:0] t;
        logic        found;
        logic [15:0] p0;
        logic [15:0] p1;
        logic [63:0] ca;
        logic [63:0] cb;
        logic [15:0] fpos;
        logic [63:0] fcol;
        logic [15:0] lpos;
        logic [63:0] lcol;
    } t_tok;

    function automatic t_sv zx16(input logic [15:0] a);
        return t_sv'({{(SV_W-16){1'b0}}, a});
    endfunction

    function automatic logic [17:0] mag18(input t_sv a);
        t_sv m;
        m = (a < 0) ? -a : a;
        return m[17:0];
    endfunction

    function automatic logic [15:0] sat16(input t_sv a);
        logic [15:0] r;
        if (a < 0) begin
            r = 16'h0000;
        end else if (a > ONE_SV) begin
            r = 16'hFFFF;
        end else begin
            r = a[15:0];
        end
        return r;
    endfunction

    // (mag + 32767) / 65535 via reciprocal estimate plus one correction
    function automatic logic [20:0] fx_round(input logic [35:0] mag);
        logic [36:0] m;
        logic [36:0] q;
        logic [36:0] r;
        m = {1'b0, mag} + 37'd32767;
        q = (m + (m >> 16)) >> 16;
        r = m - ((q << 16) - q);
        if (r >= 37'd65535) begin
            q = q + 37'd1;
        end
        return q[20:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/grmb_cell.sv
// grmb_cell: one colour stop of the ramp plus one stage of the search token
// depends on grmb_pkg
`default_nettype none

module grmb_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [15:0]       i_pos,
    input  wire logic [63:0]       i_col,
    input  wire logic [15:0]       i_prev_pos,
    input  wire logic [63:0]       i_prev_col,
    input  wire logic [CNT_W-1:0]  i_n,
    input  wire grmb_pkg::t_tok    i_tok,
    output logic [15:0]            o_pos,
    output logic [63:0]            o_col,
    output grmb_pkg::t_tok         o_tok
);

    logic [15:0]    r_pos;
    logic [63:0]    r_col;
    grmb_pkg::t_tok r_tok;
    grmb_pkg::t_tok n_tok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pos <= i_pos;
            r_col <= i_col;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (IDX == 0) begin
                n_tok.fpos = r_pos;
                n_tok.fcol = r_col;
            end
            if (32'(i_n) == IDX + 1) begin
                n_tok.lpos = r_pos;
                n_tok.lcol = r_col;
            end
            // first span that holds t
            if (IDX > 0 && 32'(i_n) > IDX && !i_tok.found &&
                i_tok.t >= i_prev_pos && i_tok.t <= r_pos) begin
                n_tok.found = 1'b1;
                n_tok.p0    = i_prev_pos;
                n_tok.p1    = r_pos;
                n_tok.ca    = i_prev_col;
                n_tok.cb    = r_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_pos = r_pos;
    assign o_col = r_col;
    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: rtl/core/grmb_div.sv
// grmb_div: restoring divider, one quotient bit per cycle, 16-bit quotient
// depends on grmb_pkg
`default_nettype none

module grmb_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [15:0]      o_quo
);

    localparam int CW = $clog2(grmb_pkg::DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [15:0]   r_rem;
    logic [15:0]   r_sh;
    logic [15:0]   r_den;
    logic [16:0]   w_rem_sh;
    logic          w_ge;

    assign w_rem_sh = {r_rem, r_sh[15]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(grmb_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[31:16];
            r_sh  <= i_num[15:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 16'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[15:0];
            r_sh  <= {r_sh[14:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

`default_nettype wire

FILE: rtl/core/gradient_ramp_map_blend.sv
// gradient_ramp_map_blend: top level, stop cell row, divider and blend datapath
// depends on grmb_pkg, grmb_cell, grmb_div
//
// usage
//   input channel (i_valid / o_ready): cmd 0 loads one colour stop into the
//   cell at stop_index (slots at or past MAX_STOPS are dropped), no result;
//   cmd 1 is a pixel: value plus backdrop rgba, one result transfer
//   output channel (o_valid / i_ready): blended rgba, saturated to 0..65535
//   config port: apb-style, stop count at 0x0, blend select at 0x4, opacity at 0x8
// timing
//   a pixel walks its token through the row of stop cells, then goes
//   through the divider when the value falls inside a span wider than 6,
//   then through multiply / round for interpolation, opacity and blend,
//   and then into the output register
//   one pixel is in work at a time; no new input is taken until its
//   result has gone into the output register
// reset
//   stop count 0, blend select normal, opacity 65535, no result pending;
//   stop table contents are unknown until loaded
// stalls
//   the result waits in the output register; a new item is taken meanwhile,
//   and the next result waits in the datapath until the register frees
`default_nettype none

module gradient_ramp_map_blend #(
    parameter int MAX_STOPS = grmb_pkg::MAX_STOPS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_cmd,
    input  wire logic [3:0]                   i_stop_index,
    input  wire logic [15:0]                  i_stop_position,
    input  wire logic signed [17:0]           i_value,
    input  wire logic [15:0]                  i_red,
    input  wire logic [15:0]                  i_green,
    input  wire logic [15:0]                  i_blue,
    input  wire logic [15:0]                  i_alpha,
    // output channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [15:0]                       o_out_red,
    output logic [15:0]                       o_out_green,
    output logic [15:0]                       o_out_blue,
    output logic [15:0]                       o_out_alpha,
    // config port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [grmb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CNT_W = $clog2(MAX_STOPS + 1);

    // config registers
    logic [4:0]  r_count;
    logic [2:0]  r_mode;
    logic [15:0] r_opacity;

    // control
    grmb_pkg::t_state r_state;
    grmb_pkg::t_state n_state;
    grmb_pkg::t_phase r_phase;
    grmb_pkg::t_phase n_phase;
    logic             r_ovalid;

    // pixel datapath
    logic signed [17:0] r_v;
    logic [15:0]        r_d    [4];
    grmb_pkg::t_sv      r_val  [4];
    grmb_pkg::t_sv      r_b    [4];
    grmb_pkg::t_sv      r_base [4];
    logic               r_neg  [4];
    logic [35:0]        r_mag  [4];
    logic [15:0]        r_f;
    logic [15:0]        r_ored;
    logic [15:0]        r_ogreen;
    logic [15:0]        r_oblue;
    logic [15:0]        r_oalpha;

    logic            w_cfg_wr;
    logic            w_in_acc;
    logic            w_load;
    logic            w_out_load;
    logic            w_div_start;
    logic            w_div_done;
    logic [15:0]     w_quo;
    logic [CNT_W-1:0] w_n;
    grmb_pkg::t_tok  w_launch;
    grmb_pkg::t_tok  w_tok [MAX_STOPS+1];
    grmb_pkg::t_tok  w_last;
    logic [15:0]     w_pos [MAX_STOPS];
    logic [63:0]     w_col [MAX_STOPS];
    logic [63:0]     w_stop_col;

    // scan decision
    grmb_pkg::t_sv w_a  [4];
    grmb_pkg::t_sv w_bb [4];
    logic          w_need_div;
    logic [15:0]   w_range;
    logic [15:0]   w_dt;
    logic [31:0]   w_num;

    // multiply operands and round results
    grmb_pkg::t_sv w_x    [4];
    grmb_pkg::t_sv w_y    [4];
    grmb_pkg::t_sv w_base [4];
    grmb_pkg::t_sv w_adj  [4];

    // ---------------- config port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 5'd0;
            r_mode    <= grmb_pkg::MODE_NORMAL;
            r_opacity <= 16'hFFFF;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                grmb_pkg::REG_COUNT:   r_count   <= pwdata[4:0];
                grmb_pkg::REG_MODE:    r_mode    <= pwdata[2:0];
                grmb_pkg::REG_OPACITY: r_opacity <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            grmb_pkg::REG_COUNT:   prdata = {27'd0, r_count};
            grmb_pkg::REG_MODE:    prdata = {29'd0, r_mode};
            grmb_pkg::REG_OPACITY: prdata = {16'd0, r_opacity};
            default:               prdata = 32'd0;
        endcase
    end

    // stop count as seen by the cells, capped at the row length
    assign w_n = (32'(r_count) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(r_count);

    // ---------------- input side ----------------
    assign w_in_acc   = i_valid && o_ready;
    assign w_load     = w_in_acc && (i_cmd == grmb_pkg::CMD_LOAD);
    assign w_stop_col = {i_alpha, i_blue, i_green, i_red};

    // token enters cell 0 with the clamped value
    always_comb begin
        w_launch       = '0;
        w_launch.valid = w_in_acc && (i_cmd == grmb_pkg::CMD_PIXEL);
        if (i_value < 0) begin
            w_launch.t = 16'h0000;
        end else if (i_value > 18'sd65535) begin
            w_launch.t = 16'hFFFF;
        end else begin
            w_launch.t = i_value[15:0];
        end
    end

    assign w_tok[0] = w_launch;

    // ---------------- row of stop cells ----------------
    for (genvar gi = 0; gi < MAX_STOPS; gi++) begin : g_cell
        logic [15:0] w_prev_pos;
        logic [63:0] w_prev_col;

        if (gi == 0) begin : g_head
            assign w_prev_pos = '0;
            assign w_prev_col = '0;
        end else begin : g_link
            assign w_prev_pos = w_pos[gi-1];
            assign w_prev_col = w_col[gi-1];
        end

        grmb_cell #(
            .IDX   (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_we       (w_load && (32'(i_stop_index) == gi)),
            .i_pos      (i_stop_position),
            .i_col      (w_stop_col),
            .i_prev_pos (w_prev_pos),
            .i_prev_col (w_prev_col),
            .i_n        (w_n),
            .i_tok      (w_tok[gi]),
            .o_pos      (w_pos[gi]),
            .o_col      (w_col[gi]),
            .o_tok      (w_tok[gi+1])
        );
    end

    assign w_last = w_tok[MAX_STOPS];

    // ---------------- ramp colour selection ----------------
    assign w_range = w_last.p1 - w_last.p0;
    assign w_dt    = w_last.t - w_last.p0;
    // (t - p0) * 65535 + range / 2
    assign w_num   = ({w_dt, 16'h0000} - {16'h0000, w_dt}) + {17'd0, w_range[15:1]};

    always_comb begin
        w_need_div = 1'b0;
        for (int k = 0; k < 4; k++) begin
            w_a[k]  = grmb_pkg::zx16(w_last.t);
            w_bb[k] = grmb_pkg::zx16(w_last.t);
        end
        w_a[3]  = grmb_pkg::ONE_SV;
        w_bb[3] = grmb_pkg::ONE_SV;
        if (w_n == '0) begin
            // no stops: grey of the raw signed value
            for (int k = 0; k < 3; k++) begin
                w_a[k]  = grmb_pkg::SV_W'(r_v);
                w_bb[k] = grmb_pkg::SV_W'(r_v);
            end
        end else if (w_last.t <= w_last.fpos) begin
            for (int k = 0; k < 4; k++) begin
                w_a[k]  = grmb_pkg::zx16(w_last.fcol[16*k +: 16]);
                w_bb[k] = w_a[k];
            end
        end else if (w_last.t >= w_last.lpos) begin
            for (int k = 0; k < 4; k++) begin
                w_a[k]  = grmb_pkg::zx16(w_last.lcol[16*k +: 16]);
                w_bb[k] = w_a[k];
            end
        end else if (w_last.found) begin
            for (int k = 0; k < 4; k++) begin
                w_a[k]  = grmb_pkg::zx16(w_last.ca[16*k +: 16]);
                w_bb[k] = grmb_pkg::zx16(w_last.cb[16*k +: 16]);
            end
            // spans of width 6 or less keep the lower colour
            w_need_div = w_range >= 16'd7;
        end
    end

    assign w_div_start = (r_state == grmb_pkg::S_SCAN) && w_last.valid && w_need_div;

    grmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_range),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // ---------------- multiply operands per phase ----------------
    always_comb begin
        grmb_pkg::t_sv s3;
        grmb_pkg::t_sv inv;
        grmb_pkg::t_sv dk;
        s3  = r_val[3];
        inv = grmb_pkg::ONE_SV - s3;
        for (int k = 0; k < 4; k++) begin
            dk        = grmb_pkg::zx16(r_d[k]);
            w_x[k]    = '0;
            w_y[k]    = '0;
            w_base[k] = r_val[k];
            case (r_phase)
                grmb_pkg::PH_INTERP: begin
                    w_x[k] = r_b[k] - r_val[k];
                    w_y[k] = grmb_pkg::zx16(r_f);
                end
                grmb_pkg::PH_OPAC: begin
                    w_base[k] = '0;
                    w_x[k]    = r_val[k];
                    w_y[k]    = grmb_pkg::zx16(r_opacity);
                end
                default: begin
                    if (k == 3) begin
                        // alpha lane
                        case (r_mode) inside
                            grmb_pkg::MODE_ADD: w_base[k] = dk + r_val[k];
                            grmb_pkg::MODE_SUB: w_base[k] = dk;
                            grmb_pkg::MODE_NORMAL, grmb_pkg::MODE_MULTIPLY,
                            grmb_pkg::MODE_SCREEN, grmb_pkg::MODE_OVERLAY: begin
                                w_x[k] = dk;
                                w_y[k] = inv;
                            end
                            default: w_base[k] = r_val[k];
                        endcase
                    end else begin
                        case (r_mode)
                            grmb_pkg::MODE_NORMAL: begin
                                w_x[k] = dk;
                                w_y[k] = inv;
                            end
                            grmb_pkg::MODE_MULTIPLY: begin
                                w_base[k] = '0;
                                w_x[k]    = dk;
                                w_y[k]    = r_val[k];
                            end
                            grmb_pkg::MODE_SCREEN: begin
                                w_base[k] = grmb_pkg::ONE_SV;
                                w_x[k]    = dk - grmb_pkg::ONE_SV;
                                w_y[k]    = grmb_pkg::ONE_SV - r_val[k];
                            end
                            grmb_pkg::MODE_OVERLAY: begin
                                if (r_d[k] < 16'd32768) begin
                                    w_base[k] = '0;
                                    w_x[k]    = dk + dk;
                                    w_y[k]    = r_val[k];
                                end else begin
                                    w_base[k] = grmb_pkg::ONE_SV;
                                    w_x[k]    = (dk - grmb_pkg::ONE_SV) + (dk - grmb_pkg::ONE_SV);
                                    w_y[k]    = grmb_pkg::ONE_SV - r_val[k];
                                end
                            end
                            grmb_pkg::MODE_ADD: w_base[k] = dk + r_val[k];
                            grmb_pkg::MODE_SUB: w_base[k] = dk - r_val[k];
                            default:            w_base[k] = r_val[k];
                        endcase
                    end
                end
            endcase
        end
    end

    // symmetric rounding of the registered products
    always_comb begin
        grmb_pkg::t_sv q;
        for (int k = 0; k < 4; k++) begin
            q        = grmb_pkg::SV_W'(grmb_pkg::fx_round(r_mag[k]));
            w_adj[k] = r_base[k] + (r_neg[k] ? -q : q);
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            grmb_pkg::S_IDLE: begin
                if (w_in_acc && i_cmd == grmb_pkg::CMD_PIXEL) begin
                    n_state = grmb_pkg::S_SCAN;
                end
            end
            grmb_pkg::S_SCAN: begin
                if (w_last.valid) begin
                    n_state = w_need_div ? grmb_pkg::S_DIV : grmb_pkg::S_MUL;
                    n_phase = grmb_pkg::PH_INTERP;
                end
            end
            grmb_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = grmb_pkg::S_MUL;
                end
            end
            grmb_pkg::S_MUL: n_state = grmb_pkg::S_ADJ;
            grmb_pkg::S_ADJ: begin
                unique case (r_phase)
                    grmb_pkg::PH_INTERP: begin
                        n_phase = grmb_pkg::PH_OPAC;
                        n_state = grmb_pkg::S_MUL;
                    end
                    grmb_pkg::PH_OPAC: begin
                        n_phase = grmb_pkg::PH_BLEND;
                        n_state = grmb_pkg::S_MUL;
                    end
                    default: n_state = grmb_pkg::S_OUT;
                endcase
            end
            grmb_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = grmb_pkg::S_IDLE;
                end
            end
            default: n_state = grmb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_state == grmb_pkg::S_IDLE);
        w_out_load = (r_state == grmb_pkg::S_OUT) && (!r_ovalid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= grmb_pkg::S_IDLE;
            r_phase  <= grmb_pkg::PH_INTERP;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_cmd == grmb_pkg::CMD_PIXEL) begin
            r_v    <= i_value;
            r_d[0] <= i_red;
            r_d[1] <= i_green;
            r_d[2] <= i_blue;
            r_d[3] <= i_alpha;
        end
        if (r_state == grmb_pkg::S_SCAN && w_last.valid) begin
            for (int k = 0; k < 4; k++) begin
                r_val[k] <= w_a[k];
                r_b[k]   <= w_bb[k];
            end
            r_f <= 16'd0;
        end
        if (r_state == grmb_pkg::S_DIV && w_div_done) begin
            r_f <= w_quo;
        end
        if (r_state == grmb_pkg::S_MUL) begin
            for (int k = 0; k < 4; k++) begin
                r_mag[k]  <= grmb_pkg::mag18(w_x[k]) * grmb_pkg::mag18(w_y[k]);
                r_neg[k]  <= (w_x[k] < 0) ^ (w_y[k] < 0);
                r_base[k] <= w_base[k];
            end
        end
        if (r_state == grmb_pkg::S_ADJ) begin
            for (int k = 0; k < 4; k++) begin
                r_val[k] <= w_adj[k];
            end
        end
        if (w_out_load) begin
            r_ored   <= grmb_pkg::sat16(r_val[0]);
            r_ogreen <= grmb_pkg::sat16(r_val[1]);
            r_oblue  <= grmb_pkg::sat16(r_val[2]);
            r_oalpha <= grmb_pkg::sat16(r_val[3]);
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_red   = r_ored;
    assign o_out_green = r_ogreen;
    assign o_out_blue  = r_oblue;
    assign o_out_alpha = r_oalpha;

endmodule

`default_nettype wire

FILE: rtl/core/grmb_checker.sv
// grmb_checker: port-level assertions for the gradient ramp map, bound to the top
// depends on grmb_pkg and gradient_ramp_map_blend
`default_nettype none

module grmb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_cmd,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_out_red,
    input wire logic [15:0] o_out_alpha
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its red and alpha payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_red) && $stable(o_out_alpha))
        else $error("result changed while stalled");

    // a load transfer never produces a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == grmb_pkg::CMD_LOAD |=> !$rose(o_valid))
        else $error("result after a stop load");

    // a pixel transfer occupies the block
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == grmb_pkg::CMD_PIXEL |=> !o_ready)
        else $error("input taken while a pixel is in work");

endmodule

bind gradient_ramp_map_blend grmb_checker u_grmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_red   (o_out_red),
    .o_out_alpha (o_out_alpha)
);

`default_nettype wire
